/* sv/svc_pkg.sv */
// Shared types, constants and the helper function of the separable vignetting corrector.
`default_nettype none
package svc_pkg;

  localparam int unsigned MAX_WIDTH      = 4096;
  localparam int unsigned MAX_HEIGHT     = 4096;
  localparam int unsigned GAIN_FRAC_BITS = 14;
  localparam int unsigned PIXEL_BITS     = 16;

  localparam int unsigned XW       = $clog2(MAX_WIDTH);
  localparam int unsigned YW       = $clog2(MAX_HEIGHT);
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned P1_W     = PIXEL_BITS + GAIN_W;
  localparam int unsigned P2_W     = P1_W + GAIN_W;
  localparam int unsigned RND_SH   = 2 * GAIN_FRAC_BITS;
  localparam int unsigned RES_W    = P2_W + 1 - RND_SH;
  localparam int unsigned IN_DATA_W = 72;

  typedef enum logic [1:0] {
    MODE_COL = 2'd0,
    MODE_ROW = 2'd1,
    MODE_PIX = 2'd2,
    MODE_NOP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_SHIFT_X = 2'd0,
    REG_SHIFT_Y = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                  valid;
    mode_e                 mode;
    logic [IDX_W-1:0]      idx;
    logic [GAIN_W-1:0]     gain;
    logic [PIXEL_BITS-1:0] pix;
    logic [XW-1:0]         x;
    logic [YW-1:0]         y;
  } coord_t;

  typedef struct packed {
    logic                  valid;
    logic [PIXEL_BITS-1:0] pix;
    logic [GAIN_W-1:0]     gx;
    logic [GAIN_W-1:0]     gy;
  } gain_t;

  function automatic logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v, logic [CFG_W-1:0] depth);
    logic [CFG_W-1:0] s;
    s = v;
    if (s == '0) begin
      s = CFG_W'(1);
    end
    if (s > depth) begin
      s = depth;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* sv/svc_coord.sv */
// Configuration registers and coordinate shift and clamp stage.
`default_nettype none
module svc_coord (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          fire_i,
  input  wire svc_pkg::mode_e                mode_i,
  input  wire logic [svc_pkg::IDX_W-1:0]     idx_i,
  input  wire logic [svc_pkg::GAIN_W-1:0]    gain_i,
  input  wire logic [svc_pkg::PIXEL_BITS-1:0] pix_i,
  input  wire logic [11:0]                   col_i,
  input  wire logic [11:0]                   row_i,
  input  wire logic                          cfg_we_i,
  input  wire svc_pkg::cfg_reg_e             cfg_index_i,
  input  wire logic [svc_pkg::CFG_W-1:0]     cfg_data_i,
  output svc_pkg::coord_t                    item_o
);

  localparam logic [svc_pkg::CFG_W-1:0] DEPTH_X = svc_pkg::CFG_W'(svc_pkg::MAX_WIDTH);
  localparam logic [svc_pkg::CFG_W-1:0] DEPTH_Y = svc_pkg::CFG_W'(svc_pkg::MAX_HEIGHT);

  logic [svc_pkg::CFG_W-1:0] shift_x_q, shift_y_q, width_q, height_q;
  logic [svc_pkg::CFG_W-1:0] w_eff, h_eff, w_lim, h_lim;
  logic signed [svc_pkg::SUM_W-1:0] sum_x, sum_y;
  logic [svc_pkg::XW-1:0] x_d;
  logic [svc_pkg::YW-1:0] y_d;
  logic                           valid_q;
  svc_pkg::mode_e                 mode_q;
  logic [svc_pkg::IDX_W-1:0]      idx_q;
  logic [svc_pkg::GAIN_W-1:0]     gain_q;
  logic [svc_pkg::PIXEL_BITS-1:0] pix_q;
  logic [svc_pkg::XW-1:0]         x_q;
  logic [svc_pkg::YW-1:0]         y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_x_q <= '0;
      shift_y_q <= '0;
      width_q   <= svc_pkg::CFG_W'(4096);
      height_q  <= svc_pkg::CFG_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        svc_pkg::REG_SHIFT_X: shift_x_q <= cfg_data_i;
        svc_pkg::REG_SHIFT_Y: shift_y_q <= cfg_data_i;
        svc_pkg::REG_WIDTH:   width_q   <= cfg_data_i;
        svc_pkg::REG_HEIGHT:  height_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = svc_pkg::eff_size(width_q, DEPTH_X);
    h_eff = svc_pkg::eff_size(height_q, DEPTH_Y);
    w_lim = w_eff - svc_pkg::CFG_W'(1);
    h_lim = h_eff - svc_pkg::CFG_W'(1);
    sum_x = $signed({2'b00, col_i}) + $signed({shift_x_q[svc_pkg::CFG_W-1], shift_x_q});
    sum_y = $signed({2'b00, row_i}) + $signed({shift_y_q[svc_pkg::CFG_W-1], shift_y_q});
    if (sum_x[svc_pkg::SUM_W-1]) begin
      x_d = '0;
    end else if (sum_x[svc_pkg::CFG_W-1:0] > w_lim) begin
      x_d = w_lim[svc_pkg::XW-1:0];
    end else begin
      x_d = sum_x[svc_pkg::XW-1:0];
    end
    if (sum_y[svc_pkg::SUM_W-1]) begin
      y_d = '0;
    end else if (sum_y[svc_pkg::CFG_W-1:0] > h_lim) begin
      y_d = h_lim[svc_pkg::YW-1:0];
    end else begin
      y_d = sum_y[svc_pkg::YW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q <= mode_i;
      idx_q  <= idx_i;
      gain_q <= gain_i;
      pix_q  <= pix_i;
      x_q    <= x_d;
      y_q    <= y_d;
    end
  end

  assign item_o = '{valid: valid_q, mode: mode_q, idx: idx_q, gain: gain_q, pix: pix_q,
                    x: x_q, y: y_q};

endmodule
`default_nettype wire

/* sv/svc_gain_mem.sv */
// Column and row gain memories with table writes and registered gain reads.
`default_nettype none
module svc_gain_mem (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire svc_pkg::coord_t item_i,
  output svc_pkg::gain_t       gain_o
);

  logic [svc_pkg::GAIN_W-1:0] col_mem [svc_pkg::MAX_WIDTH];
  logic [svc_pkg::GAIN_W-1:0] row_mem [svc_pkg::MAX_HEIGHT];
  logic col_we, row_we;
  logic                           valid_q;
  logic [svc_pkg::PIXEL_BITS-1:0] pix_q;
  logic [svc_pkg::GAIN_W-1:0]     gx_q;
  logic [svc_pkg::GAIN_W-1:0]     gy_q;

  assign col_we = en_i && item_i.valid && (item_i.mode == svc_pkg::MODE_COL) &&
                  (32'(item_i.idx) < svc_pkg::MAX_WIDTH);
  assign row_we = en_i && item_i.valid && (item_i.mode == svc_pkg::MODE_ROW) &&
                  (32'(item_i.idx) < svc_pkg::MAX_HEIGHT);

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[item_i.idx[svc_pkg::XW-1:0]] <= item_i.gain;
    end
    if (en_i) begin
      gx_q <= col_mem[item_i.x];
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[item_i.idx[svc_pkg::YW-1:0]] <= item_i.gain;
    end
    if (en_i) begin
      gy_q <= row_mem[item_i.y];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= item_i.valid && (item_i.mode == svc_pkg::MODE_PIX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= item_i.pix;
    end
  end

  assign gain_o = '{valid: valid_q, pix: pix_q, gx: gx_q, gy: gy_q};

endmodule
`default_nettype wire

/* sv/svc_mult.sv */
// Two-stage gain multiplier with rounding, saturation and the output register.
`default_nettype none
module svc_mult (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire svc_pkg::gain_t                  gain_i,
  output logic                                 valid_o,
  output logic [svc_pkg::PIXEL_BITS-1:0]       pixel_o,
  output logic                                 sat_o
);

  localparam logic [svc_pkg::P2_W:0] HALF = (svc_pkg::P2_W + 1)'(1) << (svc_pkg::RND_SH - 1);

  logic                         s3_valid_q, s4_valid_q, out_valid_q;
  logic [svc_pkg::P1_W-1:0]     p1_q;
  logic [svc_pkg::GAIN_W-1:0]   gy_q;
  logic [svc_pkg::P2_W-1:0]     p2_q;
  logic [svc_pkg::P2_W:0]       rnd;
  logic [svc_pkg::RES_W-1:0]    res;
  logic                         sat_d;
  logic [svc_pkg::PIXEL_BITS-1:0] pixel_d, pixel_q;
  logic                         sat_q;

  always_comb begin
    rnd   = {1'b0, p2_q} + HALF;
    res   = rnd[svc_pkg::P2_W:svc_pkg::RND_SH];
    sat_d = |res[svc_pkg::RES_W-1:svc_pkg::PIXEL_BITS];
    pixel_d = sat_d ? '1 : res[svc_pkg::PIXEL_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q  <= gain_i.valid;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= svc_pkg::P1_W'(gain_i.pix) * svc_pkg::P1_W'(gain_i.gx);
      gy_q    <= gain_i.gy;
      p2_q    <= svc_pkg::P2_W'(p1_q) * svc_pkg::P2_W'(gy_q);
      pixel_q <= pixel_d;
      sat_q   <= sat_d;
    end
  end

  assign valid_o = out_valid_q;
  assign pixel_o = pixel_q;
  assign sat_o   = sat_q;

endmodule
`default_nettype wire

/* sv/separable_vignetting_correction.sv */
// Top level of the separable vignetting corrector: stream ports, pipeline wiring, checks.
//
// Channel   Direction  Payload
// s_axis    in         tdata: table_index, gain_value, pixel_value, col, row; tuser: mode
// m_axis    out        tdata: corrected_pixel; tuser: saturated
// cfg       in         cfg_index_i selects the register, cfg_data_i is the value
//
// One transaction is accepted per cycle while the output is not stalled.
// The gain memories are read and written in the same pipeline stage, so the order of table
// writes and pixel reads matches the order of accepted transactions with no forwarding.
// The whole pipeline advances together; it stalls only while a result waits at the output.
// Reset restores the configuration defaults and clears the pipeline valid bits; gain tables
// are not cleared.
`default_nettype none
module separable_vignetting_correction (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: table_index[11:0], gain_value[27:12], pixel_value[43:28], col[55:44], row[67:56]
  input  wire logic [svc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  wire logic [1:0]                  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // tdata: corrected_pixel[15:0]
  output logic [15:0]                      m_axis_tdata,
  // tuser: saturated[0]
  output logic                             m_axis_tuser,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [svc_pkg::CFG_W-1:0]   cfg_data_i
);

  logic            en, fire;
  svc_pkg::coord_t item;
  svc_pkg::gain_t  gain;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign fire          = s_axis_tvalid && en;
  assign cfg_ready_o   = 1'b1;

  svc_coord u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .fire_i      (fire),
    .mode_i      (svc_pkg::mode_e'(s_axis_tuser)),
    .idx_i       (s_axis_tdata[11:0]),
    .gain_i      (s_axis_tdata[27:12]),
    .pix_i       (s_axis_tdata[43:28]),
    .col_i       (s_axis_tdata[55:44]),
    .row_i       (s_axis_tdata[67:56]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (svc_pkg::cfg_reg_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .item_o      (item)
  );

  svc_gain_mem u_gain_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .item_i (item),
    .gain_o (gain)
  );

  svc_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .gain_i  (gain),
    .valid_o (m_axis_tvalid),
    .pixel_o (m_axis_tdata),
    .sat_o   (m_axis_tuser)
  );

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while the output is stalled");

  a_sat_is_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'hFFFF)
    else $error("saturated result is not full scale");

  a_stall_keeps_gain_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain.valid && !en |=> gain.valid && $stable(gain.pix))
    else $error("gain stage lost a pixel during a stall");

  a_write_makes_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && item.valid && item.mode != svc_pkg::MODE_PIX |=> !gain.valid)
    else $error("table write produced a pixel in the gain stage");
`endif

endmodule
`default_nettype wire
